[rtl/core/mts_pkg.sv]
`default_nettype none

package mts_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // result tdata: popped, is_empty, top, min, count, zero pad to bytes
    localparam int RES_BITS   = VALUE_W + 1 + VALUE_W + VALUE_W + COUNT_W;
    localparam int RES_DATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W  = VALUE_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

endpackage

`default_nettype wire

[rtl/core/mts_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write port, one read port, registered read.
module mts_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/min_tracking_stack.sv]
`default_nettype none

// Bounded LIFO of signed 32-bit values with running-minimum tracking.
// Each input transfer is a push, pop or peek (kind on s_axis_tuser, kind 3
// acts as a peek) and yields exactly one result transfer carrying status
// (on m_axis_tuser), the popped value, and the empty flag, top, minimum and
// count after the operation. The top entry and its minimum live in
// registers; the entries below it sit in one RAM word each (value plus the
// minimum at that level). Push, peek, errors and a pop that empties the
// stack are answered from the registers; a pop that exposes a stored
// entry waits in ST_LOAD for the registered RAM read. Items are handled
// one at a time. The result sits in an output register, so a new item is
// taken in the same cycle that the previous result is taken. Overflow and
// underflow leave the state untouched. There is no clearing pass over the
// RAM after reset; only the registers reset.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] value
    input  wire logic [KIND_W-1:0]     s_axis_tuser,  // [1:0] kind

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] popped_value, [32] is_empty, [64:33] top_value,
    // [96:65] min_value, [101:97] entry_count, upper bits zero
    output logic      [RES_DATA_W-1:0] m_axis_tdata,
    output logic      [STATUS_W-1:0]   m_axis_tuser   // [1:0] status
);

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W  = 2 * VALUE_W;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    // pack one result word
    function automatic logic [RES_DATA_W-1:0] pack_result(
        input logic [VALUE_W-1:0] popped,
        input logic [CW-1:0]      cnt,
        input logic [VALUE_W-1:0] topv,
        input logic [VALUE_W-1:0] minv
    );
        logic [CW+4:0]            cnt_ext;
        logic                     empty;
        logic [RES_DATA_W-1:0]    res;
        cnt_ext = (CW+5)'(cnt);
        empty   = (cnt == '0);
        res     = '0;
        res[VALUE_W-1:0]                        = popped;
        res[VALUE_W]                            = empty;
        res[2*VALUE_W:VALUE_W+1]                = empty ? '0 : topv;
        res[3*VALUE_W:2*VALUE_W+1]              = empty ? '0 : minv;
        res[3*VALUE_W+COUNT_W:3*VALUE_W+1]      = cnt_ext[COUNT_W-1:0];
        return res;
    endfunction

    state_t                state_reg,      state_next;
    logic [CW-1:0]         count_reg,      count_next;
    logic [VALUE_W-1:0]    top_val_reg,    top_val_next;
    logic [VALUE_W-1:0]    top_min_reg,    top_min_next;
    logic [VALUE_W-1:0]    popped_reg,     popped_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [RES_DATA_W-1:0] out_data_reg,   out_data_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [MEM_W-1:0]      ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [MEM_W-1:0]      ram_rdata;

    logic                  accept;
    logic [KIND_W-1:0]     in_kind;
    logic [VALUE_W-1:0]    in_value;
    logic [CW-1:0]         count_dec1;
    logic [CW-1:0]         count_dec2;
    logic [CW-1:0]         count_inc;
    logic                  is_full;
    logic [VALUE_W-1:0]    push_min;

    assign in_kind  = s_axis_tuser;
    assign in_value = s_axis_tdata[VALUE_W-1:0];

    // one item in flight; output slot must be free or draining this cycle
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign count_dec1 = count_reg - CW'(1);
    assign count_dec2 = count_reg - CW'(2);
    assign count_inc  = count_reg + CW'(1);
    assign is_full    = (count_reg == CW'(DEPTH));

    // bottom entry's minimum is its own value
    assign push_min = ((count_reg == '0) || ($signed(in_value) < $signed(top_min_reg)))
                      ? in_value : top_min_reg;

    // old top goes to the RAM on push; entry below top comes back on pop
    assign ram_waddr = count_dec1[ADDR_W-1:0];
    assign ram_wdata = {top_min_reg, top_val_reg};
    assign ram_raddr = count_dec2[ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_val_next    = top_val_reg;
        top_min_next    = top_min_reg;
        popped_next     = popped_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_kind)
                        KIND_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = STATUS_OVERFLOW;
                                out_data_next   = pack_result('0, count_reg,
                                                              top_val_reg, top_min_reg);
                            end
                            else
                            begin
                                ram_we          = (count_reg != '0);
                                top_val_next    = in_value;
                                top_min_next    = push_min;
                                count_next      = count_inc;
                                out_status_next = STATUS_OK;
                                out_data_next   = pack_result('0, count_inc,
                                                              in_value, push_min);
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_UNDERFLOW;
                                out_data_next   = pack_result('0, count_reg,
                                                              top_val_reg, top_min_reg);
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next      = '0;
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_OK;
                                out_data_next   = pack_result(top_val_reg, '0,
                                                              top_val_reg, top_min_reg);
                            end
                            else
                            begin
                                // new top must be fetched from the RAM
                                ram_re      = 1'b1;
                                popped_next = top_val_reg;
                                count_next  = count_dec1;
                                state_next  = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_OK;
                            out_data_next   = pack_result('0, count_reg,
                                                          top_val_reg, top_min_reg);
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                top_val_next    = ram_rdata[VALUE_W-1:0];
                top_min_next    = ram_rdata[MEM_W-1:VALUE_W];
                out_valid_next  = 1'b1;
                out_status_next = STATUS_OK;
                out_data_next   = pack_result(popped_reg, count_reg,
                                              ram_rdata[VALUE_W-1:0],
                                              ram_rdata[MEM_W-1:VALUE_W]);
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            top_val_reg    <= '0;
            top_min_reg    <= '0;
            popped_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            top_val_reg    <= top_val_next;
            top_min_reg    <= top_min_next;
            popped_reg     <= popped_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    mts_ram #(
        .WIDTH  (MEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fill count stays within the stack bound
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    // the RAM read cycle of a pop always finds the output slot free
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> !out_valid_reg)
        else $error("output slot busy during pop fetch");

    // a pop fetch is only started with at least two entries held
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> count_reg >= CW'(2))
        else $error("RAM read with fewer than two entries");

    // underflow reports an empty stack and nothing popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_UNDERFLOW)
            |-> (out_data_reg[VALUE_W] && out_data_reg[VALUE_W-1:0] == '0))
        else $error("underflow result not empty");

    // reported minimum never exceeds reported top
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg[VALUE_W])
            |-> ($signed(out_data_reg[3*VALUE_W:2*VALUE_W+1])
                 <= $signed(out_data_reg[2*VALUE_W:VALUE_W+1])))
        else $error("minimum above top");

endmodule

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    // Unused kind code; the block treats it as a peek.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int RANDOM_OPS     = 730;   // random operations after the directed part
    localparam int LONG_HOLD      = 300;   // cycles the sink holds tready low once
    localparam int HOLD_AFTER     = 300;   // results seen before that hold starts
    localparam int SETTLE_CYCLES  = 10;    // quiet time at the end
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer before giving up
    localparam int MAX_REPORTS    = 10;

    // One expected result transfer.
    typedef struct {
        status_t                status;
        logic [VALUE_W-1:0]     popped;
        logic                   empty;
        logic [VALUE_W-1:0]     top;
        logic [VALUE_W-1:0]     minimum;
        logic [COUNT_W-1:0]     count;
    } stack_result_t;

    // Shadow copy of the stack plus the queue of results still owed by the block.
    class min_stack_scoreboard;
        logic signed [VALUE_W-1:0] values [DEPTH_DEFAULT];
        logic signed [VALUE_W-1:0] mins   [DEPTH_DEFAULT];
        int unsigned               fill;
        stack_result_t             pending_results [$];

        int errors;
        int results_checked;
        int n_push, n_pop, n_peek, n_overflow, n_underflow, deepest;

        function void fail(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void compare(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
            if (got !== want)
                fail($sformatf("%s expected %h got %h (result %0d)",
                               field, want, got, results_checked));
        endfunction

        // Apply one accepted operation to the shadow stack and queue its result.
        function void note_op(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
            stack_result_t r;
            r.status  = STATUS_OK;
            r.popped  = '0;
            r.top     = '0;
            r.minimum = '0;
            if (kind == KIND_PUSH) begin
                n_push++;
                if (fill >= DEPTH_DEFAULT) begin
                    r.status = STATUS_OVERFLOW;
                    n_overflow++;
                end
                else begin
                    values[fill] = value;
                    // running minimum is signed; bottom entry takes its own value
                    if (fill > 0 && mins[fill - 1] < $signed(value))
                        mins[fill] = mins[fill - 1];
                    else
                        mins[fill] = value;
                    fill++;
                end
            end
            else if (kind == KIND_POP) begin
                n_pop++;
                if (fill == 0) begin
                    r.status = STATUS_UNDERFLOW;
                    n_underflow++;
                end
                else begin
                    fill--;
                    r.popped = values[fill];
                end
            end
            else begin
                n_peek++;
            end
            if (fill > deepest)
                deepest = fill;
            if (fill > 0) begin
                r.top     = values[fill - 1];
                r.minimum = mins[fill - 1];
            end
            r.empty = (fill == 0);
            r.count = COUNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result transfer with the oldest expectation.
        function void check_result(logic [RES_DATA_W-1:0] data, logic [STATUS_W-1:0] user);
            stack_result_t r;
            if (pending_results.size() == 0) begin
                fail($sformatf("result with nothing outstanding: tuser %h tdata %h",
                               user, data));
                return;
            end
            r = pending_results.pop_front();
            compare("status",       r.status,  user);
            compare("popped_value", r.popped,  data[31:0]);
            compare("is_empty",     r.empty,   data[32]);
            compare("top_value",    r.top,     data[64:33]);
            compare("min_value",    r.minimum, data[96:65]);
            compare("entry_count",  r.count,   data[101:97]);
            compare("tdata pad",    '0,        data[RES_DATA_W-1:RES_BITS]);
            results_checked++;
        endfunction
    endclass

    min_stack_scoreboard sb = new;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;       // [31:0] value
    logic [KIND_W-1:0]       s_axis_tuser = KIND_PEEK; // [1:0] kind

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [31:0] popped_value, [32] is_empty, [64:33] top_value,
    // [96:65] min_value, [101:97] entry_count, upper bits zero
    logic [RES_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;            // [1:0] status

    min_tracking_stack #(
        .DEPTH(DEPTH_DEFAULT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one operation and hold it until the block takes it. All drives are
    // nonblocking at the rising edge, and tready is read at the edge before the
    // block's own updates land, so the transfer edge is seen exactly.
    task automatic send_op(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_op(kind, value);
    endtask

    // Source gap; a zero gap leaves tvalid high for back-to-back transfers.
    task automatic idle_source(int unsigned cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Source pause until every owed result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mix of full-range values, small signed values (lots of ties with the
    // running minimum) and values at the signed extremes.
    function automatic logic [VALUE_W-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom;
        if (pick < 7)
            return VALUE_W'($urandom_range(0, 40)) - VALUE_W'(20);
        if (pick < 8)
            return 32'h7FFF_FFFF - VALUE_W'($urandom_range(0, 3));
        if (pick < 9)
            return 32'h8000_0000 + VALUE_W'($urandom_range(0, 3));
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    // Push-heavy phases fill the stack to overflow, pop-heavy ones empty it.
    function automatic logic [KIND_W-1:0] rand_kind(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return KIND_PUSH;
        if (r < push_pct + (100 - push_pct) * 3 / 4)
            return KIND_POP;
        return $urandom_range(0, 1) ? KIND_PEEK : KIND_SPARE;
    endfunction

    // Source side: directed sequence, then random phases.
    initial
    begin
        int unsigned done;
        int unsigned phase_left;
        int unsigned push_pct;
        int unsigned burst;
        bit          gaps_on;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack: underflow, peek and the spare code all report zeros
        send_op(KIND_POP,   32'hDEAD_BEEF);
        send_op(KIND_PEEK,  32'hFFFF_FFFF);
        send_op(KIND_SPARE, 32'h1234_5678);
        // extremes; the minimum must follow the signed order
        send_op(KIND_PUSH,  32'h7FFF_FFFF);
        send_op(KIND_PUSH,  32'h8000_0000);
        send_op(KIND_PUSH,  32'h0000_0000);
        send_op(KIND_PUSH,  32'hFFFF_FFFF);
        // pops back down past the minimum, which reverts to the bottom entry
        send_op(KIND_POP,   32'hFFFF_FFFF);
        send_op(KIND_POP,   32'h0000_0000);
        send_op(KIND_POP,   32'h5555_5555);
        // fill to full, then overflow and a pop from full
        for (int i = 1; i < DEPTH_DEFAULT; i++)
            send_op(KIND_PUSH, (i % 2) ? -VALUE_W'(i * 7) : VALUE_W'(i * 1000));
        send_op(KIND_PUSH,  32'hAAAA_AAAA);
        send_op(KIND_POP,   32'h0000_0000);
        drain_results();

        done       = 0;
        phase_left = 0;
        push_pct   = 50;
        gaps_on    = 1'b1;
        while (done < RANDOM_OPS) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                gaps_on    = ($urandom_range(0, 3) != 0);
                phase_left = $urandom_range(20, 60);
            end
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && done < RANDOM_OPS; i++) begin
                send_op(rand_kind(push_pct), rand_value());
                done++;
                if (phase_left > 0)
                    phase_left--;
                // one full pause mid-run: everything in flight must come back
                if (done == RANDOM_OPS / 2)
                    drain_results();
            end
            if (gaps_on)
                idle_source($urandom_range(0, 6));
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d ops: %0d pushes (%0d overflow), %0d pops (%0d underflow), %0d peeks",
                 sb.n_push + sb.n_pop + sb.n_peek, sb.n_push, sb.n_overflow,
                 sb.n_pop, sb.n_underflow, sb.n_peek);
        $display("deepest fill %0d of %0d, %0d results checked, %0d mismatches",
                 sb.deepest, DEPTH_DEFAULT, sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Sink side: checks each result transfer and drives tready from a
    // changing stall pattern, with one long hold-off that backs the block up
    // while the source keeps offering operations.
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          held;

        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (!held && sb.results_checked >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;                        // no stalls
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
                    default: m_axis_tready <= ~m_axis_tready;             // alternating
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    initial
    begin
        int unsigned quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, sb.pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
